FILE: design/iprt_pkg.sv
package iprt_pkg;

    typedef enum logic [2:0] {
        CMD_LOOKUP     = 3'd0,
        CMD_ADD        = 3'd1,
        CMD_ADD_STATIC = 3'd2,
        CMD_ADD_PREFIX = 3'd3,
        CMD_DEL_PREFIX = 3'd4,
        CMD_DEL_IFACE  = 3'd5,
        CMD_CLEAR      = 3'd6,
        CMD_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISS      = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_SHIFT,
        FSM_DONE
    } fsm_t;

    localparam logic [1:0] SRC_MANUAL = 2'd0;
    localparam logic [1:0] SRC_RA = 2'd1;
    localparam logic [7:0] MAX_LEN = 8'd128;
    localparam logic [15:0] DEFAULT_METRIC_RST = 16'd10;

    // One route entry
    typedef struct packed {
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        logic [7:0]  prefix_len;
        logic [15:0] metric;
        logic [1:0]  source;
        logic [7:0]  iface;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
    } route_t;

    // Compare results from the shared unit
    typedef struct packed {
        logic match;
        logic exact;
        logic ranks_below;
        logic iface_eq;
    } cmp_t;

    // Leading-bit mask for up to 64 bits
    function automatic logic [63:0] lead_mask(input logic [6:0] k);
        logic [63:0] m;
        begin
            if (k == 7'd0)
                m = '0;
            else if (k >= 7'd64)
                m = '1;
            else
                m = ~64'd0 << (7'd64 - k);
            return m;
        end
    endfunction

endpackage

FILE: design/iprt_cmp.sv
module iprt_cmp #(
    parameter int TIME_BITS = 32
) (
    input  iprt_pkg::route_t             ent,
    input  logic [TIME_BITS-1:0]         ent_expiry,
    input  logic [63:0]                  key_hi,
    input  logic [63:0]                  key_lo,
    input  logic [7:0]                   key_len,
    input  logic [15:0]                  key_metric,
    input  logic [1:0]                   key_source,
    input  logic [7:0]                   key_iface,
    input  logic [TIME_BITS-1:0]         now,
    output iprt_pkg::cmp_t               res,
    output logic                         expired
);
    import iprt_pkg::*;

    logic [7:0]  len_c;
    logic [63:0] mh;
    logic [63:0] ml;

    // Clamp length, build masks
    always_comb
    begin
        len_c = (ent.prefix_len > MAX_LEN) ? MAX_LEN : ent.prefix_len;
        mh = lead_mask((len_c >= 8'd64) ? 7'd64 : len_c[6:0]);
        ml = lead_mask((len_c >= 8'd64) ? 7'(len_c - 8'd64) : 7'd0);
    end

    // Shared compares
    always_comb
    begin
        res.match = (((key_hi ^ ent.prefix_hi) & mh) == '0) &&
                    (((key_lo ^ ent.prefix_lo) & ml) == '0);
        res.exact = (ent.source == key_source) && (ent.prefix_hi == key_hi) &&
                    (ent.prefix_lo == key_lo) && (ent.prefix_len == key_len);
        res.ranks_below = (key_len > ent.prefix_len) ||
                          ((key_len == ent.prefix_len) && (key_metric < ent.metric));
        res.iface_eq = (ent.iface == key_iface);
        expired = (ent_expiry != '0) && (now > ent_expiry);
    end

endmodule

FILE: design/ipv6_route_table_lpm_top.sv
// Channel | Dir | Signals                         | Content
// s_axis  | in  | s_tvalid s_tready s_tdata       | one command
// m_axis  | out | m_tvalid m_tready m_tdata       | one result
// apb     | in  | psel penable pwrite paddr ...   | default_metric at 0x0
// A request is taken only when the sequencer is idle and the result register is
// empty. One comparator checks one entry a cycle; inserts and removals move one
// slot a cycle. Each expired advertisement route that a lookup drops adds a
// compaction pass, after which the lookup resumes at the removed slot.
// Reset clears the route count; a stalled result blocks the next request.
module ipv6_route_table_lpm_top #(
    parameter int ENTRIES   = 16,
    parameter int TIME_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    // cmd[2:0] addr_hi[66:3] addr_lo[130:67] prefix_len[138:131]
    // metric[154:139] source[156:155] iface[164:157] hop_hi[228:165]
    // hop_lo[292:229] expiry[324:293] now[356:325], zero fill to 360
    input  logic [359:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // status[1:0] out_iface[9:2] out_hop_hi[73:10] out_hop_lo[137:74]
    // out_metric[153:138] out_prefix_len[161:154] route_count[166:162], fill 168
    output logic [167:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import iprt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // Entry storage
    route_t               ent_mem [ENTRIES];
    logic [TIME_BITS-1:0] exp_mem [ENTRIES];

    fsm_t state_reg, state_next;
    logic [CW-1:0] used_reg;
    logic [15:0]   dmet_reg;
    logic [CW-1:0] idx_reg;     // scan pointer
    logic [IW-1:0] wr_reg;      // compaction write pointer
    logic [IW-1:0] pos_reg;     // slot where a lookup last dropped a route
    cmd_t          cmd_reg;
    route_t        key_reg;
    logic [TIME_BITS-1:0] kexp_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [1:0]    stat_reg;
    route_t        hit_reg;
    logic          hit_v_reg;
    logic [167:0]  out_reg;
    logic          ov_reg;

    logic [IW-1:0] idx_a;
    logic [IW-1:0] rd_a;
    cmp_t          cres;
    logic          expd;
    route_t        cur;
    logic [TIME_BITS-1:0] cur_exp;
    cmd_t          in_cmd;
    logic          is_ins;
    logic          scan_end;
    logic          full;
    logic          ra_drop;
    logic          last_ent;
    logic          move_up;

    always_comb
        is_ins = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_ADD_STATIC) ||
                 (cmd_reg == CMD_ADD_PREFIX);

    // Point the comparator at the slot below while inserting
    assign idx_a = IW'(idx_reg);
    always_comb
    begin
        if (state_reg == FSM_SHIFT && is_ins)
            rd_a = idx_a - IW'(1);
        else
            rd_a = idx_a;
    end

    assign cur     = ent_mem[rd_a];
    assign cur_exp = exp_mem[rd_a];
    assign in_cmd  = cmd_t'(s_tdata[2:0]);

    iprt_cmp #(.TIME_BITS(TIME_BITS)) u_cmp (
        .ent(cur), .ent_expiry(cur_exp),
        .key_hi(key_reg.prefix_hi), .key_lo(key_reg.prefix_lo),
        .key_len(key_reg.prefix_len), .key_metric(key_reg.metric),
        .key_source(key_reg.source), .key_iface(key_reg.iface),
        .now(now_reg), .res(cres), .expired(expd)
    );

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, dmet_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dmet_reg <= DEFAULT_METRIC_RST;
        else if (psel && penable && pwrite && pready && paddr == 2'd0)
            dmet_reg <= pwdata[15:0];
    end

    assign s_tready = (state_reg == FSM_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    assign scan_end = (idx_reg >= used_reg);
    assign full     = (used_reg >= CW'(ENTRIES));
    assign ra_drop  = cres.match && expd && (cur.source == SRC_RA);
    assign last_ent = ((idx_reg + CW'(1)) >= used_reg);
    assign move_up  = (idx_reg != '0) && cres.ranks_below;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (s_tvalid && s_tready)
                    state_next = FSM_SCAN;
            end
            FSM_SCAN:
            begin
                if (scan_end)
                    state_next = (is_ins && !full) ? FSM_SHIFT : FSM_DONE;
                else
                begin
                    unique case (cmd_reg) inside
                        CMD_LOOKUP:
                        begin
                            if (ra_drop)
                                state_next = FSM_SHIFT;
                            else if (cres.match && !expd)
                                state_next = FSM_DONE;
                        end
                        CMD_DEL_PREFIX:
                        begin
                            if (cres.exact)
                                state_next = FSM_SHIFT;
                        end
                        CMD_DEL_IFACE:
                        begin
                            if (last_ent)
                                state_next = FSM_DONE;
                        end
                        CMD_ADD_PREFIX:
                        begin
                            if (cres.exact)
                                state_next = FSM_DONE;
                        end
                        CMD_ADD, CMD_ADD_STATIC: ;
                        default: state_next = FSM_DONE;
                    endcase
                end
            end
            FSM_SHIFT:
            begin
                if (is_ins)
                begin
                    if (!move_up)
                        state_next = FSM_DONE;
                end
                else if (idx_reg >= used_reg)
                begin
                    state_next = (cmd_reg == CMD_LOOKUP) ? FSM_SCAN : FSM_DONE;
                end
            end
            FSM_DONE:  state_next = FSM_IDLE;
            default:   state_next = FSM_IDLE;
        endcase
    end

    // Sequencer datapath: SCAN walks entries; SHIFT moves slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
            wr_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && m_tready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                FSM_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        cmd_reg <= in_cmd;
                        key_reg.prefix_hi  <= s_tdata[66:3];
                        key_reg.prefix_lo  <= s_tdata[130:67];
                        key_reg.prefix_len <= s_tdata[138:131];
                        // Prefix inserts carry metric 0; static metric 0 takes the default
                        key_reg.metric     <= (in_cmd == CMD_ADD_PREFIX) ? 16'd0 :
                                              (in_cmd == CMD_ADD_STATIC &&
                                               s_tdata[154:139] == 16'd0) ? dmet_reg :
                                              s_tdata[154:139];
                        key_reg.source     <= (in_cmd == CMD_ADD_STATIC) ? SRC_MANUAL :
                                              s_tdata[156:155];
                        key_reg.iface      <= s_tdata[164:157];
                        key_reg.hop_hi     <= (in_cmd == CMD_ADD_PREFIX) ? 64'd0 :
                                              s_tdata[228:165];
                        key_reg.hop_lo     <= (in_cmd == CMD_ADD_PREFIX) ? 64'd0 :
                                              s_tdata[292:229];
                        kexp_reg <= (in_cmd == CMD_ADD_STATIC) ? TIME_BITS'(0) :
                                    TIME_BITS'(s_tdata[324:293]);
                        now_reg  <= TIME_BITS'(s_tdata[356:325]);
                        idx_reg <= '0;
                        wr_reg  <= '0;
                        hit_v_reg <= 1'b0;
                        stat_reg <= ST_OK;
                        if (in_cmd == CMD_CLEAR)
                            used_reg <= '0;
                    end
                end
                FSM_SCAN:
                begin
                    if (scan_end)
                    begin
                        // End of walk with no early exit
                        unique case (cmd_reg) inside
                            CMD_LOOKUP: stat_reg <= ST_MISS;
                            CMD_DEL_PREFIX: stat_reg <= ST_NOT_FOUND;
                            CMD_DEL_IFACE: used_reg <= CW'(wr_reg);
                            CMD_ADD, CMD_ADD_STATIC, CMD_ADD_PREFIX:
                            begin
                                if (full)
                                    stat_reg <= ST_FULL;
                                else
                                    idx_reg <= used_reg;
                            end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        unique case (cmd_reg) inside
                            CMD_LOOKUP:
                            begin
                                if (ra_drop)
                                begin
                                    // Remove in place: compact from here
                                    wr_reg  <= rd_a;
                                    pos_reg <= rd_a;
                                    idx_reg <= idx_reg + CW'(1);
                                end
                                else if (cres.match && !expd)
                                begin
                                    hit_reg <= cur;
                                    hit_v_reg <= 1'b1;
                                end
                                else
                                    idx_reg <= idx_reg + CW'(1);
                            end
                            CMD_DEL_PREFIX:
                            begin
                                if (cres.exact)
                                    wr_reg <= rd_a;
                                idx_reg <= idx_reg + CW'(1);
                            end
                            CMD_DEL_IFACE:
                            begin
                                // Keep non-matching entries, packing downward
                                if (!cres.iface_eq)
                                begin
                                    ent_mem[wr_reg] <= cur;
                                    exp_mem[wr_reg] <= cur_exp;
                                    wr_reg <= wr_reg + IW'(1);
                                end
                                if (last_ent)
                                    used_reg <= CW'(wr_reg) + CW'(!cres.iface_eq);
                                else
                                    idx_reg <= idx_reg + CW'(1);
                            end
                            CMD_ADD_PREFIX:
                            begin
                                if (cres.exact)
                                begin
                                    ent_mem[rd_a].iface <= key_reg.iface;
                                    exp_mem[rd_a] <= kexp_reg;
                                end
                                else
                                    idx_reg <= idx_reg + CW'(1);
                            end
                            CMD_ADD, CMD_ADD_STATIC: idx_reg <= used_reg;
                            default: ;
                        endcase
                    end
                end
                FSM_SHIFT:
                begin
                    if (is_ins)
                    begin
                        // Walk down from the tail, moving entries up one slot
                        if (move_up)
                        begin
                            ent_mem[idx_a] <= cur;
                            exp_mem[idx_a] <= cur_exp;
                            idx_reg <= idx_reg - CW'(1);
                        end
                        else
                        begin
                            ent_mem[idx_a] <= key_reg;
                            exp_mem[idx_a] <= kexp_reg;
                            used_reg <= used_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        // Close the gap at wr_reg
                        if (idx_reg < used_reg)
                        begin
                            ent_mem[wr_reg] <= cur;
                            exp_mem[wr_reg] <= cur_exp;
                            wr_reg <= wr_reg + IW'(1);
                            idx_reg <= idx_reg + CW'(1);
                        end
                        else
                        begin
                            used_reg <= used_reg - CW'(1);
                            // Resume a lookup at the removed slot
                            if (cmd_reg == CMD_LOOKUP)
                                idx_reg <= CW'(pos_reg);
                        end
                    end
                end
                FSM_DONE:
                begin
                    ov_reg <= 1'b1;
                    out_reg <= {1'b0, 5'(used_reg),
                                hit_v_reg ? {hit_reg.prefix_len, hit_reg.metric,
                                             hit_reg.hop_lo, hit_reg.hop_hi,
                                             hit_reg.iface} : 160'd0,
                                stat_reg};
                end
                default: ;
            endcase
        end
    end

endmodule
